// File: design/htc_pkg.sv
// Shared constants, types and register codes of the hysteresis threshold controller.
package htc_pkg;

  localparam int unsigned HOLD_BITS  = 24;
  localparam int unsigned TICK_STEP  = 1;
  localparam int unsigned CNT_W      = HOLD_BITS + 2;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAP_W      = 15;
  localparam int unsigned THR_W      = SAMPLE_W + 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = (HOLD_BITS > SAMPLE_W) ? HOLD_BITS : SAMPLE_W;

  typedef logic [HOLD_BITS-1:0]       hold_t;
  typedef logic signed [CNT_W-1:0]    cnt_t;
  typedef logic signed [THR_W-1:0]    thr_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Counter saturates at 2^(HOLD_BITS+1) - 1
  localparam cnt_t  CNT_TOP  = cnt_t'((64'd1 << (HOLD_BITS + 1)) - 64'd1);
  localparam hold_t HOLD_INF = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD_BASE  = 3'd0,
    REG_HYST_GAP        = 3'd1,
    REG_ACTIVE_ABOVE    = 3'd2,
    REG_ACTIVE_MEANS_ON = 3'd3,
    REG_ACTIVE_HOLD_MIN = 3'd4,
    REG_ACTIVE_HOLD_MAX = 3'd5,
    REG_IDLE_HOLD_MIN   = 3'd6,
    REG_IDLE_HOLD_MAX   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    sample_t           threshold_base;
    logic [GAP_W-1:0]  hyst_gap;
    logic              active_above;
    logic              active_means_on;
    hold_t             active_hold_min;
    hold_t             active_hold_max;
    hold_t             idle_hold_min;
    hold_t             idle_hold_max;
  } cfg_t;

  typedef struct packed {
    sample_t sample;
    logic    current_on;
    logic    manual_event;
    logic    active_reload_valid;
    hold_t   active_reload_ticks;
    logic    idle_reload_valid;
    hold_t   idle_reload_ticks;
  } item_t;

  typedef struct packed {
    logic toggle;
    logic new_on;
  } result_t;

endpackage

// File: design/htc_if.sv
// Channel interfaces: sample input, decision output and configuration write.
interface htc_in_if import htc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    current_on;
  logic    manual_event;
  logic    active_reload_valid;
  hold_t   active_reload_ticks;
  logic    idle_reload_valid;
  hold_t   idle_reload_ticks;

  modport source (output valid, sample, current_on, manual_event, active_reload_valid,
                  active_reload_ticks, idle_reload_valid, idle_reload_ticks,
                  input ready);
  modport sink (input valid, sample, current_on, manual_event, active_reload_valid,
                active_reload_ticks, idle_reload_valid, idle_reload_ticks,
                output ready);
endinterface

interface htc_out_if;
  logic valid;
  logic ready;
  logic toggle;
  logic new_on;

  modport source (output valid, toggle, new_on, input ready);
  modport sink (input valid, toggle, new_on, output ready);
endinterface

interface htc_cfg_if import htc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/htc_core.sv
// Hold counter and switching decision for one item.
module htc_core import htc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output result_t result_o
);

  cnt_t                    cnt_q, cnt_d;
  logic signed [CNT_W:0]   cnt_sum;
  cnt_t                    cnt_inc;
  logic                    in_active;
  hold_t                   hmin, hmax, rl_ticks;
  logic                    rl_valid;
  cnt_t                    hmin_c, hmax_c;
  thr_t                    base_x, gap_x, sample_x, deact, thr;
  logic                    region_below, past, expired;
  result_t                 res;

  always_comb begin
    cnt_sum = {cnt_q[CNT_W-1], cnt_q} + (CNT_W+1)'(TICK_STEP);
    // saturate at the top of the counter range
    if (cnt_sum > $signed({1'b0, CNT_TOP})) begin
      cnt_inc = CNT_TOP;
    end else begin
      cnt_inc = cnt_sum[CNT_W-1:0];
    end

    in_active = (item_i.current_on == cfg_i.active_means_on);
    hmin      = in_active ? cfg_i.active_hold_min : cfg_i.idle_hold_min;
    hmax      = in_active ? cfg_i.active_hold_max : cfg_i.idle_hold_max;
    rl_valid  = in_active ? item_i.active_reload_valid : item_i.idle_reload_valid;
    rl_ticks  = in_active ? item_i.active_reload_ticks : item_i.idle_reload_ticks;
    hmin_c    = $signed({2'b00, hmin});
    hmax_c    = $signed({2'b00, hmax});

    base_x   = $signed({{2{cfg_i.threshold_base[SAMPLE_W-1]}}, cfg_i.threshold_base});
    gap_x    = $signed({3'b000, cfg_i.hyst_gap});
    sample_x = $signed({{2{item_i.sample[SAMPLE_W-1]}}, item_i.sample});
    deact    = cfg_i.active_above ? (base_x - gap_x) : (base_x + gap_x);
    thr      = in_active ? deact : base_x;
    region_below = (in_active != cfg_i.active_above);

    past    = ((sample_x > thr) == region_below) && (cnt_inc > hmin_c);
    expired = (hmax != HOLD_INF) && (cnt_inc > hmax_c);

    cnt_d      = cnt_inc;
    res.toggle = 1'b0;
    if (item_i.manual_event) begin
      // override never toggles; it reloads the counter when the reload is valid
      if (rl_valid) begin
        cnt_d = hmin_c - $signed({2'b00, rl_ticks});
      end
    end else if (past || expired) begin
      cnt_d      = '0;
      res.toggle = 1'b1;
    end
    res.new_on = res.toggle ? !item_i.current_on : item_i.current_on;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  assign result_o = res;

endmodule

// File: design/hysteresis_threshold_controller_top.sv
// Top level: configuration registers, input stage, decision core and output register.
// An item goes from the input stage to the result register; each holds one item.
// Throughput: one item per cycle while the output is not stalled by out_o.ready.
// The hold counter takes its next value as an item passes from the input stage to the result.
// Reset clears the hold counter, the valid flags and sets the registers to their defaults.
// Configuration writes are taken every cycle.
module hysteresis_threshold_controller_top import htc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  htc_in_if.sink    in_i,
  htc_out_if.source out_o,
  htc_cfg_if.sink   cfg_i
);

  cfg_t    cfg_q;
  item_t   item_q;
  logic    s1_valid_q;
  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    advance;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_base  <= '0;
      cfg_q.hyst_gap        <= '0;
      cfg_q.active_above    <= 1'b1;
      cfg_q.active_means_on <= 1'b1;
      cfg_q.active_hold_min <= '0;
      cfg_q.active_hold_max <= HOLD_INF;
      cfg_q.idle_hold_min   <= '0;
      cfg_q.idle_hold_max   <= HOLD_INF;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_THRESHOLD_BASE:  cfg_q.threshold_base  <= cfg_i.data[SAMPLE_W-1:0];
        REG_HYST_GAP:        cfg_q.hyst_gap        <= cfg_i.data[GAP_W-1:0];
        REG_ACTIVE_ABOVE:    cfg_q.active_above    <= cfg_i.data[0];
        REG_ACTIVE_MEANS_ON: cfg_q.active_means_on <= cfg_i.data[0];
        REG_ACTIVE_HOLD_MIN: cfg_q.active_hold_min <= cfg_i.data[HOLD_BITS-1:0];
        REG_ACTIVE_HOLD_MAX: cfg_q.active_hold_max <= cfg_i.data[HOLD_BITS-1:0];
        REG_IDLE_HOLD_MIN:   cfg_q.idle_hold_min   <= cfg_i.data[HOLD_BITS-1:0];
        REG_IDLE_HOLD_MAX:   cfg_q.idle_hold_max   <= cfg_i.data[HOLD_BITS-1:0];
      endcase
    end
  end

  // move the staged item on when the result register is free or being drained
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.sample              <= in_i.sample;
      item_q.current_on          <= in_i.current_on;
      item_q.manual_event        <= in_i.manual_event;
      item_q.active_reload_valid <= in_i.active_reload_valid;
      item_q.active_reload_ticks <= in_i.active_reload_ticks;
      item_q.idle_reload_valid   <= in_i.idle_reload_valid;
      item_q.idle_reload_ticks   <= in_i.idle_reload_ticks;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  htc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .result_o (res)
  );

  assign out_o.valid  = out_valid_q;
  assign out_o.toggle = out_q.toggle;
  assign out_o.new_on = out_q.new_on;

endmodule

// File: design/htc_checker.sv
// Port-level checker for the controller top level, with its bind.
module htc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_toggle_i,
  input logic out_new_on_i
);

  // an accepted item reaches the output through the input stage and the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |-> ##2 out_valid_i)
    else $error("accepted item did not reach the output");

  // input stalls only behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled while output was free");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_toggle_i) && $stable(out_new_on_i)))
    else $error("stalled result changed");

  // a result leaves only when taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("result dropped without handshake");

endmodule

bind hysteresis_threshold_controller_top htc_checker u_htc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_toggle_i (out_o.toggle),
  .out_new_on_i (out_o.new_on)
);

// File: dv/tb_hysteresis_threshold_controller_top.sv
// Testbench of the hysteresis threshold controller: directed and random samples checked per item.
import htc_pkg::*;

class decision_scoreboard;
  sample_t          base;
  logic [GAP_W-1:0] gap;
  logic             above;
  logic             means_on;
  hold_t            act_min;
  hold_t            act_max;
  hold_t            idle_min;
  hold_t            idle_max;
  cnt_t             hold_cnt;
  logic             actuator_on;
  result_t          pending[$];
  int unsigned      errors;

  function new();
    base        = '0;
    gap         = '0;
    above       = 1'b1;
    means_on    = 1'b1;
    act_min     = '0;
    act_max     = HOLD_INF;
    idle_min    = '0;
    idle_max    = HOLD_INF;
    hold_cnt    = '0;
    actuator_on = 1'b0;
    errors      = 0;
  endfunction

  function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_THRESHOLD_BASE:  base = d[SAMPLE_W-1:0];
      REG_HYST_GAP:        gap = d[GAP_W-1:0];
      REG_ACTIVE_ABOVE:    above = d[0];
      REG_ACTIVE_MEANS_ON: means_on = d[0];
      REG_ACTIVE_HOLD_MIN: act_min = d[HOLD_BITS-1:0];
      REG_ACTIVE_HOLD_MAX: act_max = d[HOLD_BITS-1:0];
      REG_IDLE_HOLD_MIN:   idle_min = d[HOLD_BITS-1:0];
      REG_IDLE_HOLD_MAX:   idle_max = d[HOLD_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Work out the switch decision for one accepted sample and queue it.
  function void note_sample(item_t it);
    logic    active;
    logic    reload_ok;
    logic    toggle;
    logic    past;
    logic    expired;
    hold_t   hmin;
    hold_t   hmax;
    hold_t   reload;
    thr_t    base_x;
    thr_t    gap_x;
    thr_t    smp_x;
    thr_t    off_thr;
    thr_t    thr;
    cnt_t    min_x;
    cnt_t    max_x;
    cnt_t    reload_x;
    result_t r;
    if (hold_cnt > CNT_TOP - cnt_t'(TICK_STEP)) begin
      hold_cnt = CNT_TOP;
    end else begin
      hold_cnt = hold_cnt + cnt_t'(TICK_STEP);
    end
    active    = (it.current_on == means_on);
    hmin      = active ? act_min : idle_min;
    hmax      = active ? act_max : idle_max;
    reload_ok = active ? it.active_reload_valid : it.idle_reload_valid;
    reload    = active ? it.active_reload_ticks : it.idle_reload_ticks;
    base_x    = {{2{base[SAMPLE_W-1]}}, base};
    gap_x     = {3'b000, gap};
    smp_x     = {{2{it.sample[SAMPLE_W-1]}}, it.sample};
    off_thr   = above ? base_x - gap_x : base_x + gap_x;
    thr       = active ? off_thr : base_x;
    min_x     = {2'b00, hmin};
    max_x     = {2'b00, hmax};
    reload_x  = {2'b00, reload};
    toggle    = 1'b0;
    if (it.manual_event) begin
      // an override never toggles; it reloads the counter when the reload is valid
      if (reload_ok) hold_cnt = min_x - reload_x;
    end else begin
      past    = ((smp_x > thr) == (active != above)) && (hold_cnt > min_x);
      expired = (hmax != HOLD_INF) && (hold_cnt > max_x);
      if (past || expired) begin
        hold_cnt = '0;
        toggle   = 1'b1;
      end
    end
    r.toggle    = toggle;
    r.new_on    = toggle ? ~it.current_on : it.current_on;
    actuator_on = r.new_on;
    pending.insert(pending.size(), r);
  endfunction

  function void report(string what, logic want, logic got);
    errors++;
    $display("%0t: %s expected %0b, got %0b", $time, what, want, got);
  endfunction

  function void check_decision(result_t got);
    result_t want;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: decision with none expected, got toggle=%0b new_on=%0b",
               $time, got.toggle, got.new_on);
      return;
    end
    want = pending.pop_front();
    if (got.toggle !== want.toggle) report("toggle", want.toggle, got.toggle);
    if (got.new_on !== want.new_on) report("new_on", want.new_on, got.new_on);
  endfunction
endclass

module tb_hysteresis_threshold_controller_top;
  localparam int unsigned RANDOM_ITEMS   = 1150;
  localparam int unsigned TAIL_ITEMS     = 120;
  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int          CLK_HALF       = 4;
  localparam sample_t     SMIN           = sample_t'(16'h8000);
  localparam sample_t     SMAX           = sample_t'(16'h7FFF);

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  htc_in_if  in_if ();
  htc_out_if out_if ();
  htc_cfg_if cfg_if ();

  hysteresis_threshold_controller_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  decision_scoreboard sb = new();

  int unsigned tx_odds       = 0;
  int unsigned rx_odds       = 0;
  int unsigned rx_stall_left = 0;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Hold ready low in random bursts.
  always @(negedge clk_i) begin
    if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_if.ready  <= 1'b0;
    end else if (rx_odds != 0 && $urandom_range(rx_odds - 1) == 0) begin
      rx_stall_left <= $urandom_range(16);
      out_if.ready  <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_reg(cfg_reg_e'(cfg_if.index), cfg_if.data);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_decision(result_t'{out_if.toggle, out_if.new_on});
      end
      if (in_if.valid && in_if.ready) begin
        sb.note_sample(item_t'{in_if.sample, in_if.current_on, in_if.manual_event,
                               in_if.active_reload_valid, in_if.active_reload_ticks,
                               in_if.idle_reload_valid, in_if.idle_reload_ticks});
      end
    end
  end

  function automatic item_t make_item(sample_t smp, logic on, logic manual, logic act_ok,
                                      hold_t act_ticks, logic idle_ok, hold_t idle_ticks);
    item_t it;
    it.sample              = smp;
    it.current_on          = on;
    it.manual_event        = manual;
    it.active_reload_valid = act_ok;
    it.active_reload_ticks = act_ticks;
    it.idle_reload_valid   = idle_ok;
    it.idle_reload_ticks   = idle_ticks;
    return it;
  endfunction

  // Mostly short override times so the counter soon comes back from a deep reload.
  function automatic hold_t pick_reload();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick == 0) return hold_t'($urandom());
    if (pick == 1) return HOLD_INF;
    return hold_t'($urandom_range(40));
  endfunction

  function automatic hold_t pick_min();
    case ($urandom_range(9))
      0:       return '0;
      1:       return hold_t'($urandom());
      default: return hold_t'($urandom_range(24));
    endcase
  endfunction

  function automatic hold_t pick_max();
    case ($urandom_range(9))
      0, 1, 2: return HOLD_INF;
      3:       return hold_t'(HOLD_INF - 1);
      4:       return hold_t'($urandom());
      5:       return '0;
      default: return hold_t'($urandom_range(60));
    endcase
  endfunction

  task automatic write_cfg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // Write every register; unused upper data bits carry noise.
  task automatic write_setup(sample_t base, logic [GAP_W-1:0] gap, logic above, logic means_on,
                             hold_t amin, hold_t amax, hold_t imin, hold_t imax);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom());
    write_cfg(REG_THRESHOLD_BASE, {noise[CFG_DATA_W-1:SAMPLE_W], base});
    write_cfg(REG_HYST_GAP, {noise[CFG_DATA_W-1:GAP_W], gap});
    write_cfg(REG_ACTIVE_ABOVE, {noise[CFG_DATA_W-1:1], above});
    write_cfg(REG_ACTIVE_MEANS_ON, {~noise[CFG_DATA_W-1:1], means_on});
    write_cfg(REG_ACTIVE_HOLD_MIN, amin);
    write_cfg(REG_ACTIVE_HOLD_MAX, amax);
    write_cfg(REG_IDLE_HOLD_MIN, imin);
    write_cfg(REG_IDLE_HOLD_MAX, imax);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Send one item; a fresh item is built at the falling edge from the latest actuator state.
  task automatic drive_item(item_t it, bit fresh);
    int unsigned pick;
    int          centre;
    if (fresh && tx_odds != 0 && $urandom_range(tx_odds - 1) == 0) begin
      repeat ($urandom_range(17, 1)) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    if (fresh) begin
      // follow the actuator like a real plant, with the odd glitch
      it.current_on          = sb.actuator_on ^ ($urandom_range(15) == 0);
      it.manual_event        = ($urandom_range(9) == 0);
      it.active_reload_valid = 1'($urandom_range(1));
      it.idle_reload_valid   = 1'($urandom_range(1));
      it.active_reload_ticks = pick_reload();
      it.idle_reload_ticks   = pick_reload();
      pick = $urandom_range(9);
      if (pick == 0) begin
        it.sample = SMIN;
      end else if (pick == 1) begin
        it.sample = SMAX;
      end else if (pick <= 4) begin
        it.sample = sample_t'($urandom());
      end else begin
        // land close to one of the two thresholds
        centre = int'(sb.base);
        if ($urandom_range(1) != 0) begin
          centre = sb.above ? centre - int'(sb.gap) : centre + int'(sb.gap);
        end
        centre = centre + int'($urandom_range(16)) - 8;
        if (centre > 32767) centre = 32767;
        if (centre < -32768) centre = -32768;
        it.sample = sample_t'(centre);
      end
    end
    in_if.valid               <= 1'b1;
    in_if.sample              <= it.sample;
    in_if.current_on          <= it.current_on;
    in_if.manual_event        <= it.manual_event;
    in_if.active_reload_valid <= it.active_reload_valid;
    in_if.active_reload_ticks <= it.active_reload_ticks;
    in_if.idle_reload_valid   <= it.idle_reload_valid;
    in_if.idle_reload_ticks   <= it.idle_reload_ticks;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Stop sending and wait until every decision has come back.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned n);
    write_setup(($urandom_range(5) == 0) ? SMIN :
                ($urandom_range(4) == 0) ? SMAX : sample_t'($urandom()),
                ($urandom_range(7) == 0) ? '0 :
                ($urandom_range(6) == 0) ? '1 :
                ($urandom_range(4) == 0) ? GAP_W'($urandom()) : GAP_W'($urandom_range(300)),
                1'($urandom_range(1)), 1'($urandom_range(1)),
                pick_min(), pick_max(), pick_min(), pick_max());
    repeat (n) drive_item('0, 1'b1);
    drain();
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    in_if.valid               = 1'b0;
    in_if.sample              = '0;
    in_if.current_on          = 1'b0;
    in_if.manual_event        = 1'b0;
    in_if.active_reload_valid = 1'b0;
    in_if.active_reload_ticks = '0;
    in_if.idle_reload_valid   = 1'b0;
    in_if.idle_reload_ticks   = '0;
    cfg_if.valid              = 1'b0;
    cfg_if.index              = '0;
    cfg_if.data               = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Defaults: extremes of the sample, deep negative reload, reload with valid off.
    drive_item(make_item(SMAX, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item(SMIN, 1'b1, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item('0, 1'b1, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item(sample_t'(-1), 1'b0, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item(sample_t'(1), 1'b0, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item('0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item(SMAX, 1'b1, 1'b1, 1'b1, HOLD_INF, 1'b1, '0), 1'b0);
    drive_item(make_item(SMAX, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item(SMIN, 1'b1, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item('0, 1'b0, 1'b1, 1'b1, HOLD_INF, 1'b1, '0), 1'b0);
    drive_item(make_item('0, 1'b1, 1'b1, 1'b0, '0, 1'b1, HOLD_INF), 1'b0);
    drain();

    // Largest hold times: reach them through a reload and expire just past the maximum.
    write_setup(SMIN, '1, 1'b0, 1'b0, HOLD_INF, hold_t'(HOLD_INF - 1), HOLD_INF,
                hold_t'(HOLD_INF - 1));
    drive_item(make_item(SMAX, 1'b0, 1'b1, 1'b1, '0, 1'b0, '0), 1'b0);
    drive_item(make_item('0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item('0, 1'b1, 1'b1, 1'b0, '0, 1'b1, '0), 1'b0);
    drive_item(make_item(SMIN, 1'b1, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item(SMAX, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item(SMIN, 1'b1, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drain();

    // Zero maxima expire on every tick; widest threshold band.
    write_setup(SMAX, '1, 1'b1, 1'b1, '0, '0, '0, '0);
    drive_item(make_item(SMIN, 1'b1, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item(SMAX, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item('0, 1'b1, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drive_item(make_item(SMIN, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0), 1'b0);
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS - TAIL_ITEMS) begin
      tx_odds = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 4 : 16);
      rx_odds = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 4 : 16);
      n = $urandom_range(120, 40);
      if (n > RANDOM_ITEMS - TAIL_ITEMS - sent) n = RANDOM_ITEMS - TAIL_ITEMS - sent;
      random_phase(n);
      sent += n;
    end

    // Full rate to the end.
    tx_odds = 0;
    rx_odds = 0;
    while (rx_stall_left != 0) @(posedge clk_i);
    random_phase(TAIL_ITEMS);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Mismatches found");
    $finish;
  end
endmodule
